/* rtl/tvm_pkg.sv */
`timescale 1ns / 1ps

package tvm_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int OUT_LIMIT    = 32;

  localparam int VALUE_W = 32;
  localparam int TAG_W   = 7;
  localparam int TOL_W   = 16;
  localparam int RANK_W  = 5;
  localparam int REQ_W   = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_READ
  } state_t;

  // one stored list entry
  typedef struct packed {
    logic                     valid;
    logic [VALUE_W-1:0]       value;
    logic signed [TAG_W-1:0]  tag;
  } entry_t;

  // word traveling down the chain during an insert
  typedef struct packed {
    logic                     active;
    logic                     shift;   // position found, just push along
    logic [VALUE_W-1:0]       value;
    logic signed [TAG_W-1:0]  tag;
  } carry_t;

  // broadcast control to every cell
  typedef struct packed {
    logic clear;
    logic rotate;
  } cell_ctrl_t;

endpackage

/* rtl/tvm_cell.sv */
`timescale 1ns / 1ps

module tvm_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tvm_pkg::TOL_W-1:0]     tol,
  input  tvm_pkg::cell_ctrl_t           ctrl,
  input  tvm_pkg::carry_t               carry_in,
  output tvm_pkg::carry_t               carry_out,
  input  tvm_pkg::entry_t               rot_in,
  output tvm_pkg::entry_t               entry
);

  tvm_pkg::entry_t entry_next;
  tvm_pkg::carry_t carry_next;
  logic [tvm_pkg::VALUE_W:0] slack_sum;
  logic keep;

  // stored + tolerance >= incoming, no wrap
  assign slack_sum = {1'b0, entry.value} + {{(tvm_pkg::VALUE_W + 1 - tvm_pkg::TOL_W){1'b0}}, tol};
  assign keep = entry.valid && (slack_sum >= {1'b0, carry_in.value});

  always_comb begin
    entry_next = entry;
    carry_next = '0;
    if (ctrl.clear) begin
      entry_next.valid = 1'b0;
    end else if (ctrl.rotate) begin
      entry_next = rot_in;
    end else if (carry_in.active) begin
      if (carry_in.shift || !keep) begin
        entry_next.valid = 1'b1;
        entry_next.value = carry_in.value;
        entry_next.tag   = carry_in.tag;
        // displaced entry moves on; nothing to move if this cell was empty
        carry_next.active = entry.valid;
        carry_next.shift  = 1'b1;
        carry_next.value  = entry.value;
        carry_next.tag    = entry.tag;
      end else begin
        carry_next = carry_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid      <= 1'b0;
      carry_out.active <= 1'b0;
    end else begin
      entry.valid      <= entry_next.valid;
      carry_out.active <= carry_next.active;
    end
    entry.value     <= entry_next.value;
    entry.tag       <= entry_next.tag;
    carry_out.shift <= carry_next.shift;
    carry_out.value <= carry_next.value;
    carry_out.tag   <= carry_next.tag;
  end

endmodule

/* rtl/top_m_tagged_value_merge.sv */
`timescale 1ns / 1ps

// Top-M tagged value list: keeps the largest values seen, sorted descending.
// Command channel: a request (req_type, value, tag) is taken on a clock edge
// with start high and busy low. Insert and clear give no result word; a
// read-out gives one result word per stored entry (at most 32), with last set
// on the final one, or a single word with entry_valid low for an empty list.
// Result words appear on the output ports for one cycle each, marked by
// strobe; the receiver cannot stall, so every word must be taken as shown.
// Storage is a chain of CAPACITY cells. An insert travels down the chain one
// cell per cycle, with busy high until it has passed the last cell. A
// read-out rotates the chain toward cell 0 with busy high; its words follow
// back to back, the first registered into the result register once the
// state register has entered the read state. Clear and an empty read-out
// leave busy low; the empty-list word shows in the next cycle. A new insert
// or read-out request is not taken until the chain is done with the last.
// tie_tolerance is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset (rst, synchronous) empties the list and sets tie_tolerance to zero.

module top_m_tagged_value_merge #(
  parameter int CAPACITY = tvm_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tvm_pkg::TOL_W-1:0]           cfg_wr_data,
  input  logic                                start,
  output logic                                busy,
  input  logic [tvm_pkg::REQ_W-1:0]           req_type,
  input  logic [tvm_pkg::VALUE_W-1:0]         value,
  input  logic signed [tvm_pkg::TAG_W-1:0]    tag,
  output logic                                strobe,
  output logic                                entry_valid,
  output logic [tvm_pkg::VALUE_W-1:0]         out_value,
  output logic signed [tvm_pkg::TAG_W-1:0]    out_tag,
  output logic [tvm_pkg::RANK_W-1:0]          rank,
  output logic                                last
);

  localparam int CW = $clog2(CAPACITY + 1);  // count width
  localparam int SW = $clog2(CAPACITY);      // step counter width

  logic [tvm_pkg::TOL_W-1:0] tie_tolerance;
  logic [CW-1:0] count, count_next;
  logic [SW-1:0] step, step_next;
  tvm_pkg::state_t state, state_next;

  tvm_pkg::carry_t     carry_head;
  tvm_pkg::carry_t     carry_link [CAPACITY];
  tvm_pkg::entry_t     cell_entry [CAPACITY];
  tvm_pkg::cell_ctrl_t ctrl;

  logic accept;
  logic emit, emit_last, empty_read;

  assign accept = start && !busy;
  assign busy   = (state != tvm_pkg::ST_IDLE);

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      tie_tolerance <= '0;
    end else if (cfg_wr_en) begin
      tie_tolerance <= cfg_wr_data;
    end
  end

  // words are emitted from cell 0 while the chain rotates
  assign emit      = (state == tvm_pkg::ST_READ) && (int'(step) < int'(count))
                     && (int'(step) < tvm_pkg::OUT_LIMIT);
  assign emit_last = (int'(step) + 1 == int'(count)) || (int'(step) + 1 == tvm_pkg::OUT_LIMIT);
  assign empty_read = accept && (req_type == tvm_pkg::REQ_READ) && (count == '0);

  always_comb begin
    state_next  = state;
    step_next   = step;
    count_next  = count;
    ctrl.clear  = 1'b0;
    ctrl.rotate = 1'b0;
    unique case (state)
      tvm_pkg::ST_IDLE: begin
        step_next = '0;
        if (accept) begin
          if (req_type == tvm_pkg::REQ_INSERT) begin
            state_next = tvm_pkg::ST_INSERT;
            // not full: the word always lands; full: count holds
            if (int'(count) < CAPACITY) begin
              count_next = count + CW'(1);
            end
          end else if (req_type == tvm_pkg::REQ_READ) begin
            if (count != '0) begin
              state_next = tvm_pkg::ST_READ;
            end
          end else if (req_type == tvm_pkg::REQ_CLEAR) begin
            ctrl.clear = 1'b1;
            count_next = '0;
          end
        end
      end
      tvm_pkg::ST_INSERT: begin
        step_next = step + SW'(1);
        if (int'(step) == CAPACITY - 1) begin
          state_next = tvm_pkg::ST_IDLE;
        end
      end
      tvm_pkg::ST_READ: begin
        ctrl.rotate = 1'b1;
        step_next   = step + SW'(1);
        if (int'(step) == CAPACITY - 1) begin
          state_next = tvm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tvm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvm_pkg::ST_IDLE;
      step  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      count <= count_next;
    end
  end

  // head of the insert chain: the accepted word, live for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_head.active <= 1'b0;
    end else begin
      carry_head.active <= accept && (req_type == tvm_pkg::REQ_INSERT);
    end
    carry_head.shift <= 1'b0;
    carry_head.value <= value;
    carry_head.tag   <= tag;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    tvm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .tol       (tie_tolerance),
      .ctrl      (ctrl),
      .carry_in  ((i == 0) ? carry_head : carry_link[(i + CAPACITY - 1) % CAPACITY]),
      .carry_out (carry_link[i]),
      .rot_in    (cell_entry[(i + 1) % CAPACITY]),
      .entry     (cell_entry[i])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit || empty_read;
    end
    if (empty_read) begin
      entry_valid <= 1'b0;
      out_value   <= '0;
      out_tag     <= '0;
      rank        <= '0;
      last        <= 1'b1;
    end else begin
      entry_valid <= 1'b1;
      out_value   <= cell_entry[0].value;
      out_tag     <= cell_entry[0].tag;
      rank        <= tvm_pkg::RANK_W'(step);
      last        <= emit_last;
    end
  end

endmodule
